@@ hw/rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_WIDTH     = 32;
   localparam int FRAC_SHIFT     = 16;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_DOUBLE = 2'd1,
      KIND_TWO    = 2'd2,
      KIND_DEGEN  = 2'd3
   } kind_type;

endpackage

@@ hw/rtl/qrs_if.sv @@
// ----------------------------------------------------------------------------
// qrs_req_if / qrs_rsp_if
// Coefficient and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrs_req_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                root_kind;
   logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_plus;
   logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_minus;
   logic                                      saturated;

   modport source (output valid, root_kind, root_plus, root_minus, saturated, input ready);
   modport sink   (input valid, root_kind, root_plus, root_minus, saturated, output ready);
endinterface

@@ hw/rtl/qrs_disc.sv @@
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage discriminant: products, then b*b - 4ac and classification.
// ----------------------------------------------------------------------------
module qrs_disc #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COEF_WIDTH-1:0] coef_a,
   input  logic signed [COEF_WIDTH-1:0] coef_b,
   input  logic signed [COEF_WIDTH-1:0] coef_c,
   output logic                         out_valid,
   input  logic                         out_ready,
   output qrs_pkg::kind_type            out_kind,
   output logic [2*COEF_WIDTH:0]        out_dmag,
   output logic signed [COEF_WIDTH-1:0] out_a,
   output logic signed [COEF_WIDTH-1:0] out_b
);
   localparam int PW  = 2 * COEF_WIDTH;
   localparam int DXW = 2 * COEF_WIDTH + 3;

   logic [1:0]                   v_ff;
   logic [2:0]                   rdy;
   logic signed [PW-1:0]         bb_ff, ac_ff;
   logic signed [COEF_WIDTH-1:0] a1_ff, b1_ff;
   logic                         azero_ff;
   logic signed [DXW-1:0]        d_in;
   qrs_pkg::kind_type            kind_in, kind_ff;
   logic [PW:0]                  dmag_ff;
   logic signed [COEF_WIDTH-1:0] a2_ff, b2_ff;

   assign rdy[2]   = out_ready;
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   assign d_in = DXW'(bb_ff) - (DXW'(ac_ff) <<< 2);

   always_comb begin
      if (azero_ff) begin
         kind_in = qrs_pkg::KIND_DEGEN;
      end else if (d_in < 0) begin
         kind_in = qrs_pkg::KIND_NONE;
      end else if (d_in == '0) begin
         kind_in = qrs_pkg::KIND_DOUBLE;
      end else begin
         kind_in = qrs_pkg::KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
      end
      if (rdy[0]) begin
         bb_ff    <= coef_b * coef_b;
         ac_ff    <= coef_a * coef_c;
         a1_ff    <= coef_a;
         b1_ff    <= coef_b;
         azero_ff <= (coef_a == '0);
      end
      if (rdy[1]) begin
         kind_ff <= kind_in;
         dmag_ff <= d_in[PW:0];
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
      end
   end

   assign out_valid = v_ff[1];
   assign out_kind  = kind_ff;
   assign out_dmag  = dmag_ff;
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
endmodule

@@ hw/rtl/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root of D * 2^32, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int SIDE_WIDTH = 2 + 2 * qrs_pkg::COEF_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [2*COEF_WIDTH:0]     in_rad,
   input  logic [SIDE_WIDTH-1:0]     in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [COEF_WIDTH+16:0]    out_root,
   output logic [SIDE_WIDTH-1:0]     out_side
);
   localparam int SW = COEF_WIDTH + 17;
   localparam int XW = 2 * SW;
   localparam int RW = SW + 3;
   localparam int DW = 2 * COEF_WIDTH + 1;

   logic [SW-1:0]         v_ff;
   logic [SW:0]           rdy;
   logic [XW-1:0]         x_ff    [SW];
   logic [RW-1:0]         rem_ff  [SW];
   logic [SW-1:0]         root_ff [SW];
   logic [SIDE_WIDTH-1:0] side_ff [SW];
   logic [XW-1:0]         x0;

   assign x0       = {{(XW - 32 - DW){1'b0}}, in_rad, 32'b0};
   assign rdy[SW]  = out_ready;
   assign in_ready = rdy[0];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic [XW-1:0]         x_p;
      logic [RW-1:0]         rem_p, rem_t, trial, rem_in;
      logic [SW-1:0]         root_p;
      logic [SIDE_WIDTH-1:0] side_p;
      logic                  v_p, ge;

      if (k == 0) begin : g_first
         assign x_p    = x0;
         assign rem_p  = '0;
         assign root_p = '0;
         assign side_p = in_side;
         assign v_p    = in_valid;
      end else begin : g_next
         assign x_p    = x_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
         assign v_p    = v_ff[k-1];
      end

      assign rdy[k]  = !v_ff[k] || rdy[k+1];
      assign rem_t   = {rem_p[RW-3:0], x_p[XW-1 -: 2]};
      assign trial   = {{(RW - SW - 2){1'b0}}, root_p, 2'b01};
      assign ge      = (rem_t >= trial);
      assign rem_in  = ge ? rem_t - trial : rem_t;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_p;
         end
         if (rdy[k]) begin
            x_ff[k]    <= {x_p[XW-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_p[SW-2:0], ge};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_side  = side_ff[SW-1];
endmodule

@@ hw/rtl/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined divider: (-b*2^16 +/- s) / (2a), rounded, saturated.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  qrs_pkg::kind_type                     in_kind,
   input  logic signed [COEF_WIDTH-1:0]          in_a,
   input  logic signed [COEF_WIDTH-1:0]          in_b,
   input  logic [COEF_WIDTH+16:0]                in_root,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output qrs_pkg::kind_type                     out_kind,
   output logic [qrs_pkg::ROOT_WIDTH-1:0]        out_plus,
   output logic [qrs_pkg::ROOT_WIDTH-1:0]        out_minus,
   output logic                                  out_sat
);
   localparam int SW   = COEF_WIDTH + 17;
   localparam int NSW  = COEF_WIDTH + 19;
   localparam int NW   = COEF_WIDTH + 18;
   localparam int DVW  = COEF_WIDTH + 1;
   localparam int QCW  = (NW > 33) ? NW : 33;
   localparam int RTW  = qrs_pkg::ROOT_WIDTH;
   localparam int ST   = NW + 2;

   localparam logic [QCW-1:0] NEG_LIM = QCW'(64'h0000_0000_8000_0000);
   localparam logic [QCW-1:0] POS_LIM = QCW'(64'h0000_0000_7FFF_FFFF);

   logic [ST-1:0] v_ff;
   logic [ST:0]   rdy;

   // prep stage
   logic signed [NSW-1:0]        base, np, nm;
   logic [NSW-1:0]               npm, nmm;
   logic [COEF_WIDTH-1:0]        amag;
   logic [NW-1:0]                num_in [2];
   logic [1:0]                   neg_in;

   // division stages: index 0 holds the prep results
   logic [NW-1:0]                num_ff [NW+1][2];
   logic [NW-1:0]                q_ff   [NW+1][2];
   logic [DVW-1:0]               rem_ff [NW+1][2];
   logic [DVW-1:0]               den_ff [NW+1];
   logic [1:0]                   neg_ff [NW+1];
   qrs_pkg::kind_type            kind_ff [NW+1];

   // output stage
   qrs_pkg::kind_type            okind_ff;
   logic [RTW-1:0]               oplus_ff, ominus_ff;
   logic                         osat_ff;

   assign rdy[ST]  = out_ready;
   assign in_ready = rdy[0];

   for (genvar k = 0; k < ST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   assign base = -(NSW'(in_b) <<< qrs_pkg::FRAC_SHIFT);
   assign np   = base + signed'({{(NSW - SW){1'b0}}, in_root});
   assign nm   = base - signed'({{(NSW - SW){1'b0}}, in_root});
   assign npm  = np[NSW-1] ? -np : np;
   assign nmm  = nm[NSW-1] ? -nm : nm;
   assign amag = in_a[COEF_WIDTH-1] ? -in_a : in_a;

   assign num_in[0] = npm[NW-1:0] + NW'(amag);
   assign num_in[1] = nmm[NW-1:0] + NW'(amag);
   assign neg_in    = {nm[NSW-1] ^ in_a[COEF_WIDTH-1], np[NSW-1] ^ in_a[COEF_WIDTH-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         num_ff[0][0] <= num_in[0];
         num_ff[0][1] <= num_in[1];
         q_ff[0][0]   <= '0;
         q_ff[0][1]   <= '0;
         rem_ff[0][0] <= '0;
         rem_ff[0][1] <= '0;
         den_ff[0]    <= {amag, 1'b0};
         neg_ff[0]    <= neg_in;
         kind_ff[0]   <= in_kind;
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DVW:0] rem_t, den_x;
         logic         ge;

         assign rem_t = {rem_ff[k-1][l], num_ff[k-1][l][NW-1]};
         assign den_x = {1'b0, den_ff[k-1]};
         assign ge    = (rem_t >= den_x);

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               num_ff[k][l] <= {num_ff[k-1][l][NW-2:0], 1'b0};
               q_ff[k][l]   <= {q_ff[k-1][l][NW-2:0], ge};
               rem_ff[k][l] <= ge ? rem_t[DVW-1:0] - den_ff[k-1] : rem_t[DVW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (rdy[k]) begin
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            kind_ff[k] <= kind_ff[k-1];
         end
      end
   end

   logic [QCW-1:0] qx   [2];
   logic [RTW-1:0] qv   [2];
   logic [1:0]     qsat;
   logic           live;

   for (genvar l = 0; l < 2; l++) begin : g_sat
      always_comb begin
         qx[l] = QCW'(q_ff[NW][l]);
         if (neg_ff[NW][l]) begin
            qsat[l] = (qx[l] > NEG_LIM);
            qv[l]   = qsat[l] ? NEG_LIM[RTW-1:0] : -qx[l][RTW-1:0];
         end else begin
            qsat[l] = (qx[l] > POS_LIM);
            qv[l]   = qsat[l] ? POS_LIM[RTW-1:0] : qx[l][RTW-1:0];
         end
      end
   end

   assign live = (kind_ff[NW] == qrs_pkg::KIND_DOUBLE) || (kind_ff[NW] == qrs_pkg::KIND_TWO);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[ST-1] <= 1'b0;
      end else if (rdy[ST-1]) begin
         v_ff[ST-1] <= v_ff[ST-2];
      end
      if (rdy[ST-1]) begin
         okind_ff  <= kind_ff[NW];
         oplus_ff  <= live ? qv[0] : '0;
         ominus_ff <= live ? qv[1] : '0;
         osat_ff   <= live && (qsat != 2'b00);
      end
   end

   assign out_valid = v_ff[ST-1];
   assign out_kind  = okind_ff;
   assign out_plus  = oplus_ff;
   assign out_minus = ominus_ff;
   assign out_sat   = osat_ff;
endmodule

@@ hw/rtl/quadratic_root_solver.sv @@
// Throughput: one transaction per cycle while rsp.ready is held high; set by the
// one-bit-per-stage square root (COEF_WIDTH+17 stages) and divider
// (COEF_WIDTH+18 stages) pipelines.
// Each stage holds its item while the next is full; bubbles collapse.
// Reset: synchronous, clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in Q16.16 from Q8.8 coefficients.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   qrs_req_if.sink    req,
   qrs_rsp_if.source  rsp
);
   localparam int SIDE_WIDTH = 2 + 2 * COEF_WIDTH;

   logic                         d_valid, d_ready;
   qrs_pkg::kind_type            d_kind;
   logic [2*COEF_WIDTH:0]        d_dmag;
   logic signed [COEF_WIDTH-1:0] d_a, d_b;

   logic                         s_valid, s_ready;
   logic [COEF_WIDTH+16:0]       s_root;
   logic [SIDE_WIDTH-1:0]        s_side;

   qrs_pkg::kind_type            o_kind;

   qrs_disc #(.COEF_WIDTH(COEF_WIDTH)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .coef_a    (req.coef_a),
      .coef_b    (req.coef_b),
      .coef_c    (req.coef_c),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_kind  (d_kind),
      .out_dmag  (d_dmag),
      .out_a     (d_a),
      .out_b     (d_b)
   );

   qrs_sqrt #(.COEF_WIDTH(COEF_WIDTH), .SIDE_WIDTH(SIDE_WIDTH)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_rad    (d_dmag),
      .in_side   ({d_kind, d_a, d_b}),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   qrs_div #(.COEF_WIDTH(COEF_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_kind   (qrs_pkg::kind_type'(s_side[SIDE_WIDTH-1 -: 2])),
      .in_a      (signed'(s_side[2*COEF_WIDTH-1:COEF_WIDTH])),
      .in_b      (signed'(s_side[COEF_WIDTH-1:0])),
      .in_root   (s_root),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_kind  (o_kind),
      .out_plus  (rsp.root_plus),
      .out_minus (rsp.root_minus),
      .out_sat   (rsp.saturated)
   );

   assign rsp.root_kind = o_kind;
endmodule

@@ hw/rtl/qrs_check.sv @@
// ----------------------------------------------------------------------------
// qrs_check
// Port-level checks on the solver's result channel.
// ----------------------------------------------------------------------------
module qrs_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_root_kind,
   input logic [31:0] rsp_root_plus,
   input logic [31:0] rsp_root_minus,
   input logic        rsp_saturated
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == qrs_pkg::KIND_NONE || rsp_root_kind == qrs_pkg::KIND_DEGEN)
      |-> rsp_root_plus == '0 && rsp_root_minus == '0 && !rsp_saturated)
      else $error("no-root result carries nonzero payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == qrs_pkg::KIND_DOUBLE |-> rsp_root_plus == rsp_root_minus)
      else $error("double root with differing roots");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root_plus)
         && $stable(rsp_root_minus) && $stable(rsp_root_kind))
      else $error("stalled result changed");
endmodule

bind quadratic_root_solver qrs_check u_qrs_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_root_kind  (rsp.root_kind),
   .rsp_root_plus  (rsp.root_plus),
   .rsp_root_minus (rsp.root_minus),
   .rsp_saturated  (rsp.saturated)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streams coefficient sets into the quadratic root solver under random
// valid/ready idling, predicts each root pair and compares every response
// transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW = qrs_pkg::COEF_WIDTH_DEF;

   typedef struct {
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic signed [CW-1:0] c;
   } coef_set_type;

   typedef struct {
      qrs_pkg::kind_type kind;
      logic [31:0]       plus;
      logic [31:0]       minus;
      logic              sat;
   } root_set_type;

   logic clock;
   logic reset;

   qrs_req_if #(.COEF_WIDTH(CW)) req ();
   qrs_rsp_if                    rsp ();

   quadratic_root_solver #(.COEF_WIDTH(CW)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   coef_set_type pending_q[$];
   root_set_type roots_q[$];
   int           errors;
   int           sent;
   int           cycles;

   function automatic logic [31:0] round_clip(longint n, longint a, ref bit sat);
      longint unsigned an;
      longint unsigned aa;
      longint unsigned q;
      bit              neg;
      an  = (n < 0) ? -n : n;
      aa  = (a < 0) ? -a : a;
      q   = (an + aa) / (2 * aa);
      neg = (n < 0) != (a < 0);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1;
            q   = 64'h8000_0000;
         end
         return 32'(-longint'(q));
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1;
         q   = 64'h7FFF_FFFF;
      end
      return 32'(q);
   endfunction

   function automatic root_set_type solve_roots(coef_set_type cs);
      root_set_type r;
      longint       a;
      longint       b;
      longint       c;
      longint       d;
      longint       base;
      logic [127:0] x;
      logic [127:0] tt;
      logic [63:0]  s;
      logic [63:0]  t;
      bit           sat;
      a = cs.a;
      b = cs.b;
      c = cs.c;
      r.kind  = qrs_pkg::KIND_NONE;
      r.plus  = '0;
      r.minus = '0;
      r.sat   = 0;
      sat     = 0;
      if (a == 0) begin
         r.kind = qrs_pkg::KIND_DEGEN;
         return r;
      end
      d = b * b - 4 * a * c;
      if (d < 0) return r;
      base = -b * 65536;
      if (d == 0) begin
         r.kind  = qrs_pkg::KIND_DOUBLE;
         r.plus  = round_clip(base, a, sat);
         r.minus = r.plus;
      end else begin
         x = 128'(d) << 32;
         s = '0;
         for (int k = 49; k >= 0; k--) begin
            t  = s | (64'd1 << k);
            tt = {64'd0, t} * {64'd0, t};
            if (tt <= x) s = t;
         end
         r.kind  = qrs_pkg::KIND_TWO;
         r.plus  = round_clip(base + longint'(s), a, sat);
         r.minus = round_clip(base - longint'(s), a, sat);
      end
      r.sat = sat;
      return r;
   endfunction

   function automatic coef_set_type mk(int a, int b, int c);
      coef_set_type cs;
      cs.a = a[CW-1:0];
      cs.b = b[CW-1:0];
      cs.c = c[CW-1:0];
      return cs;
   endfunction

   function automatic int rnd_coef();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int rnd_small();
      return int'($urandom_range(64)) - 32;
   endfunction

   function automatic coef_set_type rnd_set();
      int sel;
      int p;
      int q;
      int m;
      sel = $urandom_range(9);
      case (sel)
         0: return mk(0, rnd_coef(), rnd_coef());
         1: begin
            // double root: b*b == 4*a*c
            p = $urandom_range(1, 12);
            q = $urandom_range(12);
            m = rnd_small();
            if (m == 0) m = 1;
            if ($urandom_range(1)) q = -q;
            return mk(p * p * m, 2 * p * q * m, q * q * m);
         end
         2: return mk(rnd_small(), rnd_coef(), rnd_coef());
         3: return mk(rnd_small(), rnd_small(), rnd_small());
         4: return mk(($urandom_range(1)) ? 1 : -1, rnd_coef(), rnd_coef());
         default: return mk(rnd_coef(), rnd_coef(), rnd_coef());
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      coef_set_type cs;
      bit           idle;
      cycles <= cycles + 1;
      if (reset) begin
         req.valid  <= 0;
         req.coef_a <= '0;
         req.coef_b <= '0;
         req.coef_c <= '0;
      end else begin
         if (req.valid && req.ready) begin
            cs.a = req.coef_a;
            cs.b = req.coef_b;
            cs.c = req.coef_c;
            roots_q.push_back(solve_roots(cs));
            sent <= sent + 1;
         end
         if (!req.valid || req.ready) begin
            idle = (sent < 700 || sent > 1100) && ($urandom_range(99) < 12);
            if (pending_q.size() > 0 && !idle) begin
               cs = pending_q.pop_front();
               req.valid  <= 1;
               req.coef_a <= cs.a;
               req.coef_b <= cs.b;
               req.coef_c <= cs.c;
            end else begin
               req.valid <= 0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      root_set_type ex;
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (roots_q.size() == 0) begin
               $error("unexpected response transaction");
               errors++;
            end else begin
               ex = roots_q.pop_front();
               if (rsp.root_kind !== ex.kind) begin
                  $error("root_kind: expected %0d actual %0d", ex.kind, rsp.root_kind);
                  errors++;
               end
               if (rsp.root_plus !== ex.plus) begin
                  $error("root_plus: expected %h actual %h", ex.plus, rsp.root_plus);
                  errors++;
               end
               if (rsp.root_minus !== ex.minus) begin
                  $error("root_minus: expected %h actual %h", ex.minus, rsp.root_minus);
                  errors++;
               end
               if (rsp.saturated !== ex.sat) begin
                  $error("saturated: expected %0d actual %0d", ex.sat, rsp.saturated);
                  errors++;
               end
            end
         end
         rsp.ready <= (cycles > 1500 && cycles < 2200) || ($urandom_range(99) >= 12);
      end
   end

   initial begin
      errors    = 0;
      sent      = 0;
      cycles    = 0;
      reset     = 1;
      req.valid  = 0;
      req.coef_a = '0;
      req.coef_b = '0;
      req.coef_c = '0;
      rsp.ready  = 0;
      pending_q.push_back(mk(0, 0, 0));
      pending_q.push_back(mk(0, 32767, -32768));
      pending_q.push_back(mk(256, 0, -256));
      pending_q.push_back(mk(256, 0, 256));
      pending_q.push_back(mk(256, -512, 256));
      pending_q.push_back(mk(-256, 512, -256));
      pending_q.push_back(mk(1, -32768, 0));
      pending_q.push_back(mk(1, 32767, 0));
      pending_q.push_back(mk(-1, -32768, 32767));
      pending_q.push_back(mk(-1, 32767, -32768));
      pending_q.push_back(mk(32767, 32767, 32767));
      pending_q.push_back(mk(-32768, -32768, -32768));
      pending_q.push_back(mk(32767, -32768, -32768));
      pending_q.push_back(mk(-32768, 0, 32767));
      pending_q.push_back(mk(1, 2, 1));
      pending_q.push_back(mk(1, 0, 0));
      pending_q.push_back(mk(3, 0, 0));
      pending_q.push_back(mk(2, 1, 0));
      pending_q.push_back(mk(-2, 3, 1));
      pending_q.push_back(mk(1, -32768, 32767));
      for (int i = 0; i < 1800; i++) pending_q.push_back(rnd_set());
      repeat (9) @(posedge clock);
      reset <= 0;
      while (pending_q.size() != 0 || req.valid) @(posedge clock);
      while (roots_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && roots_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
